>>> sv/psra_pkg.sv
package psra_pkg;

    localparam int MAX_SENSORS_DEF = 16;
    localparam int WINDOW_LEN_DEF  = 8;

    // field widths fixed by the item layout
    localparam int ID_W    = 16;
    localparam int ROOM_W  = 16;
    localparam int TEMP_W  = 16;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 5;

    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 72;

    localparam logic [0:0] OP_LOAD    = 1'b0;
    localparam logic [0:0] OP_READING = 1'b1;

    localparam logic [STAT_W-1:0] ST_LOADED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd2;
    localparam logic [STAT_W-1:0] ST_FILLING = 3'd3;
    localparam logic [STAT_W-1:0] ST_VALID   = 3'd4;

    localparam logic [0:0] REG_MIN_TEMP = 1'b0;
    localparam logic [0:0] REG_MAX_TEMP = 1'b1;

    localparam logic signed [TEMP_W-1:0] MIN_TEMP_RESET = 16'sd1500;
    localparam logic signed [TEMP_W-1:0] MAX_TEMP_RESET = 16'sd3000;

endpackage

>>> sv/per_sensor_running_average_alarm.sv
// Channel   Direction  Width  Contents
// s (in)    slave      80+1   tdata: probe_id, room_id, value, timestamp; tuser: op
// m (out)   master     72+3   tdata: room_out, average, flags, last_time, count; tuser: status
// cfg       write      1+16   register index, write data (min_temp, max_temp)
//
// Sequence (accept to output valid): a load, or a reading on an empty map, goes
// straight to the hand-off state. A reading scans the id table slot by slot (up to
// the matching slot, or all sensors loaded), then hands an unknown item over; a match
// updates the slot, then hands a filling item over, or sums the window through its
// single memory port, takes the magnitude, does the reciprocal multiply, restores the
// sign and compares, and hands the item to the output register.
// Reset: synchronous, active low; clears sequencer, sensor count and output
// valid, and sets the thresholds to their defaults. Memories hold no reset; a load clears its slot's state.
// Stalls: the input is ready only while the sequencer idles; a finished item
// waits in the sequencer until the output register is free.
module per_sensor_running_average_alarm #(
    parameter int MAX_SENSORS = psra_pkg::MAX_SENSORS_DEF,
    parameter int WINDOW_LEN  = psra_pkg::WINDOW_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [15:0] probe_id, [31:16] room_id, [47:32] value, [79:48] timestamp
    input  logic [psra_pkg::S_DATA_W-1:0] i_s_tdata,
    // [0] op
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [15:0] room_out, [31:16] average, [32] too_cold, [33] too_hot,
    // [65:34] last_time, [70:66] sensor_count, [71] zero
    output logic [psra_pkg::M_DATA_W-1:0] o_m_tdata,
    // [2:0] status
    output logic [psra_pkg::STAT_W-1:0]   o_m_tuser,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [psra_pkg::TEMP_W-1:0]   i_cfg_wdata
);

    localparam int IW    = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int CW    = $clog2(MAX_SENSORS + 1);
    localparam int PW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int DEPTH = MAX_SENSORS * WINDOW_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(WINDOW_LEN);
    localparam int SW    = psra_pkg::TEMP_W + LW + 1;
    localparam int QW    = psra_pkg::TEMP_W + 1;
    localparam int KW    = SW + 1;
    localparam int SH    = SW - 1 + LW;
    localparam int XW    = SW + KW;
    // ceil(2^SH / WINDOW_LEN): gives the exact floor quotient for any sum magnitude
    localparam logic [KW-1:0] RECIP =
        KW'(((64'd1 << SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_SRD  = 10'b00_0000_0010,
        S_SCMP = 10'b00_0000_0100,
        S_UPD  = 10'b00_0000_1000,
        S_WRD  = 10'b00_0001_0000,
        S_WACC = 10'b00_0010_0000,
        S_ABS  = 10'b00_0100_0000,
        S_DIV  = 10'b00_1000_0000,
        S_FIN  = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } t_state;

    t_state r_state;

    // configuration
    logic signed [psra_pkg::TEMP_W-1:0] r_min_temp, r_max_temp;

    // latched item
    logic [psra_pkg::ID_W-1:0]    r_sid;
    logic [psra_pkg::TEMP_W-1:0]  r_val;
    logic [psra_pkg::TIME_W-1:0]  r_ts;

    logic [CW-1:0] r_count;
    logic [IW-1:0] r_idx;
    logic [PW-1:0] r_j;

    // memories and their registered read data
    logic [psra_pkg::ID_W-1:0]          id_mem   [MAX_SENSORS];
    logic [psra_pkg::ROOM_W-1:0]        room_mem [MAX_SENSORS];
    logic [PW-1:0]                      pos_mem  [MAX_SENSORS];
    logic                               full_mem [MAX_SENSORS];
    logic [psra_pkg::TEMP_W-1:0]        smp_mem  [DEPTH];
    logic [psra_pkg::ID_W-1:0]          r_id_rd;
    logic [psra_pkg::ROOM_W-1:0]        r_room_rd;
    logic [PW-1:0]                      r_pos_rd;
    logic                               r_full_rd;
    logic signed [psra_pkg::TEMP_W-1:0] r_smp_rd;

    // arithmetic unit
    logic signed [SW-1:0] r_acc;
    logic [SW-1:0]        r_dvd;
    logic [QW-1:0]        r_quot;
    logic                 r_neg;

    // result held for the output register
    logic [psra_pkg::STAT_W-1:0]        r_res_status;
    logic [psra_pkg::ROOM_W-1:0]        r_res_room;
    logic signed [psra_pkg::TEMP_W-1:0] r_res_avg;
    logic                               r_res_cold, r_res_hot;
    logic [psra_pkg::TIME_W-1:0]        r_res_last;

    logic                              r_m_valid;
    logic [psra_pkg::M_DATA_W-1:0]     r_m_data;
    logic [psra_pkg::STAT_W-1:0]       r_m_user;

    logic s_acc;
    logic load_ok;
    logic table_we;
    logic state_we;
    logic [IW-1:0] state_addr;
    logic [PW-1:0] state_pos;
    logic          state_full;
    logic          pos_wrap;
    logic [AW-1:0] w_base;
    logic [XW-1:0] w_prod;
    logic [QW-1:0] w_quot;
    logic          w_out_load;
    logic signed [psra_pkg::TEMP_W-1:0] w_avg;
    logic [CW+psra_pkg::COUNT_W-1:0]    w_count_ext;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign load_ok    = (i_s_tuser == psra_pkg::OP_LOAD) && (r_count < CW'(MAX_SENSORS));
    assign table_we   = s_acc && load_ok;
    assign w_out_load = (r_state == S_OUT) && (!r_m_valid || i_m_tready);

    assign pos_wrap = (r_pos_rd == PW'(WINDOW_LEN - 1));
    assign w_base   = AW'(r_idx) * AW'(WINDOW_LEN);

    // Clear a slot's window state on load; advance it on a reading.
    always_comb begin
        state_we   = 1'b0;
        state_addr = r_idx;
        state_pos  = '0;
        state_full = 1'b0;
        if (table_we) begin
            state_we   = 1'b1;
            state_addr = r_count[IW-1:0];
        end else if (r_state == S_UPD) begin
            state_we   = 1'b1;
            state_pos  = pos_wrap ? '0 : r_pos_rd + PW'(1);
            state_full = r_full_rd | pos_wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (table_we) begin
            id_mem[r_count[IW-1:0]]   <= i_s_tdata[15:0];
            room_mem[r_count[IW-1:0]] <= i_s_tdata[31:16];
        end
        r_id_rd   <= id_mem[r_idx];
        r_room_rd <= room_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (state_we) begin
            pos_mem[state_addr]  <= state_pos;
            full_mem[state_addr] <= state_full;
        end
        r_pos_rd  <= pos_mem[r_idx];
        r_full_rd <= full_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            smp_mem[w_base + AW'(r_pos_rd)] <= r_val;
        end
        r_smp_rd <= smp_mem[w_base + AW'(r_j)];
    end

    // divide the magnitude by the window length through a reciprocal multiply
    assign w_prod = XW'(r_dvd) * XW'(RECIP);
    assign w_quot = r_neg ? (QW'(0) - r_quot) : r_quot;
    assign w_avg  = w_quot[psra_pkg::TEMP_W-1:0];

    assign w_count_ext = {{psra_pkg::COUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_min_temp <= psra_pkg::MIN_TEMP_RESET;
            r_max_temp <= psra_pkg::MAX_TEMP_RESET;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    psra_pkg::REG_MIN_TEMP: r_min_temp <= i_cfg_wdata;
                    psra_pkg::REG_MAX_TEMP: r_max_temp <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // load a finished item, or drop the valid once the item is taken
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_sid        <= i_s_tdata[15:0];
                        r_val        <= i_s_tdata[47:32];
                        r_ts         <= i_s_tdata[79:48];
                        r_idx        <= '0;
                        r_res_room   <= load_ok ? i_s_tdata[31:16] : '0;
                        r_res_avg    <= '0;
                        r_res_cold   <= 1'b0;
                        r_res_hot    <= 1'b0;
                        r_res_last   <= '0;
                        if (i_s_tuser == psra_pkg::OP_LOAD) begin
                            if (load_ok) begin
                                r_count      <= r_count + CW'(1);
                                r_res_status <= psra_pkg::ST_LOADED;
                            end else begin
                                r_res_status <= psra_pkg::ST_FULL;
                            end
                            r_state <= S_OUT;
                        end else if (r_count == '0) begin
                            r_res_status <= psra_pkg::ST_UNKNOWN;
                            r_state      <= S_OUT;
                        end else begin
                            r_state <= S_SRD;
                        end
                    end
                end
                S_SRD: begin
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    // first match wins: stop on it
                    if (r_id_rd == r_sid) begin
                        r_state <= S_UPD;
                    end else if (CW'(r_idx) + CW'(1) == r_count) begin
                        r_res_status <= psra_pkg::ST_UNKNOWN;
                        r_state      <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_SRD;
                    end
                end
                S_UPD: begin
                    r_res_room <= r_room_rd;
                    r_res_last <= r_ts;
                    r_j        <= '0;
                    r_acc      <= '0;
                    if (r_full_rd || pos_wrap) begin
                        r_state <= S_WRD;
                    end else begin
                        r_res_status <= psra_pkg::ST_FILLING;
                        r_state      <= S_OUT;
                    end
                end
                S_WRD: begin
                    r_state <= S_WACC;
                end
                S_WACC: begin
                    r_acc <= r_acc + SW'(r_smp_rd);
                    if (r_j == PW'(WINDOW_LEN - 1)) begin
                        r_state <= S_ABS;
                    end else begin
                        r_j     <= r_j + PW'(1);
                        r_state <= S_WRD;
                    end
                end
                S_ABS: begin
                    r_neg   <= r_acc[SW-1];
                    r_dvd   <= r_acc[SW-1] ? (SW'(0) - r_acc) : r_acc;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_quot  <= w_prod[SH +: QW];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // magnitude truncated, sign restored: rounds toward zero
                    r_res_avg    <= w_avg;
                    r_res_cold   <= (w_avg < r_min_temp);
                    r_res_hot    <= (w_avg > r_max_temp);
                    r_res_status <= psra_pkg::ST_VALID;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output payload, loaded together with the valid flag
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_user <= r_res_status;
            r_m_data <= {1'b0, w_count_ext[psra_pkg::COUNT_W-1:0], r_res_last,
                         r_res_hot, r_res_cold, r_res_avg, r_res_room};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SENSORS))
        else $error("sensor count beyond table depth");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        table_we |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted load did not advance the sensor count");

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_quot <= QW'(32768)))
        else $error("window average magnitude out of range");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == S_OUT))
        else $error("output valid raised outside the hand-off state");

endmodule

>>> bench/per_sensor_running_average_alarm_test.sv
module per_sensor_running_average_alarm_test;

    timeunit 1ns;
    timeprecision 1ps;

    // One input item as the sender sees it, before packing into tdata/tuser.
    typedef struct packed {
        logic [0:0]                         op;
        logic [psra_pkg::ID_W-1:0]          sid;
        logic [psra_pkg::ROOM_W-1:0]        room;
        logic signed [psra_pkg::TEMP_W-1:0] value;
        logic [psra_pkg::TIME_W-1:0]        ts;
    } t_sensor_item;

    // One result item, unpacked from tdata/tuser.
    typedef struct packed {
        logic [psra_pkg::STAT_W-1:0]        status;
        logic [psra_pkg::ROOM_W-1:0]        room;
        logic signed [psra_pkg::TEMP_W-1:0] average;
        logic                               too_cold;
        logic                               too_hot;
        logic [psra_pkg::TIME_W-1:0]        last_time;
        logic [psra_pkg::COUNT_W-1:0]       count;
    } t_alarm_result;

    // Directed script row: repeat the item reps times, stepping the sensor id
    // by sid_step; a typed result, where given, is for the last repetition.
    typedef struct {
        logic [0:0]                         op;
        logic [psra_pkg::ID_W-1:0]          sid;
        logic [psra_pkg::ID_W-1:0]          sid_step;
        logic [psra_pkg::ROOM_W-1:0]        room;
        logic signed [psra_pkg::TEMP_W-1:0] value;
        logic [psra_pkg::TIME_W-1:0]        ts;
        int                                 reps;
        bit                                 typed;
        t_alarm_result                      want;
    } t_script_row;

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 300;
    localparam int HOLD_AFTER   = 900;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [psra_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          m_tvalid;
    logic [psra_pkg::M_DATA_W-1:0] m_tdata;
    logic [psra_pkg::STAT_W-1:0]   m_tuser;
    logic                          cfg_we = 1'b0;
    logic                          cfg_idx = 1'b0;
    logic [psra_pkg::TEMP_W-1:0]   cfg_wdata = '0;

    // The receiver's own draw and the long hold-off combine into tready.
    logic rx_ready = 1'b0;
    logic rx_hold = 1'b0;
    wire  m_tready = rx_ready && !rx_hold;

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int items_taken = 0;
    int error_count = 0;

    t_alarm_result expected_alarms[$];

    // Shadow of the monitor's state: sensor map, sample rings and thresholds.
    logic [psra_pkg::ID_W-1:0]          map_id   [psra_pkg::MAX_SENSORS_DEF];
    logic [psra_pkg::ROOM_W-1:0]        map_room [psra_pkg::MAX_SENSORS_DEF];
    int                                 map_used;
    logic signed [psra_pkg::TEMP_W-1:0]
        sample_ring [psra_pkg::MAX_SENSORS_DEF][psra_pkg::WINDOW_LEN_DEF];
    int                                 ring_pos [psra_pkg::MAX_SENSORS_DEF];
    bit                                 ring_full [psra_pkg::MAX_SENSORS_DEF];
    logic signed [psra_pkg::TEMP_W-1:0] cold_limit;
    logic signed [psra_pkg::TEMP_W-1:0] hot_limit;

    t_script_row script [11];

    per_sensor_running_average_alarm i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // Work out the alarm result of one item and advance the shadow state.
    function automatic t_alarm_result predict_alarm(t_sensor_item it);
        t_alarm_result r;
        int slot;
        int sum;
        int avg;
        r = '0;
        slot = -1;
        if (it.op == psra_pkg::OP_LOAD) begin
            if (map_used < psra_pkg::MAX_SENSORS_DEF) begin
                map_id[map_used]    = it.sid;
                map_room[map_used]  = it.room;
                ring_pos[map_used]  = 0;
                ring_full[map_used] = 1'b0;
                map_used++;
                r.status = psra_pkg::ST_LOADED;
                r.room   = it.room;
            end else begin
                r.status = psra_pkg::ST_FULL;
            end
        end else begin
            // earliest loaded entry wins on duplicate ids
            for (int k = 0; k < map_used; k++) begin
                if (slot < 0 && map_id[k] == it.sid) slot = k;
            end
            if (slot < 0) begin
                r.status = psra_pkg::ST_UNKNOWN;
            end else begin
                sample_ring[slot][ring_pos[slot]] = it.value;
                ring_pos[slot]++;
                if (ring_pos[slot] >= psra_pkg::WINDOW_LEN_DEF) begin
                    ring_pos[slot]  = 0;
                    ring_full[slot] = 1'b1;
                end
                r.room      = map_room[slot];
                r.last_time = it.ts;
                if (ring_full[slot]) begin
                    sum = 0;
                    for (int j = 0; j < psra_pkg::WINDOW_LEN_DEF; j++)
                        sum += sample_ring[slot][j];
                    // integer division truncates toward zero, as the block must
                    avg = sum / psra_pkg::WINDOW_LEN_DEF;
                    r.status   = psra_pkg::ST_VALID;
                    r.average  = avg[psra_pkg::TEMP_W-1:0];
                    r.too_cold = avg < cold_limit;
                    r.too_hot  = avg > hot_limit;
                end else begin
                    r.status = psra_pkg::ST_FILLING;
                end
            end
        end
        r.count = map_used[psra_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // Offer one item after a random gap, hold it until taken, then queue its result.
    task automatic offer_item(input t_sensor_item it, input bit typed,
                              input t_alarm_result want);
        int gap;
        t_alarm_result r;
        gap = tx_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {it.ts, it.value, it.room, it.sid};
        s_tuser  = it.op;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        r = predict_alarm(it);
        expected_alarms.push_back(typed ? want : r);
        items_taken++;
        @(negedge clk);
    endtask

    // Write both thresholds on consecutive cycles while the block idles.
    task automatic set_limits(input logic signed [psra_pkg::TEMP_W-1:0] lo,
                              input logic signed [psra_pkg::TEMP_W-1:0] hi);
        cfg_we    = 1'b1;
        cfg_idx   = psra_pkg::REG_MIN_TEMP;
        cfg_wdata = lo;
        @(negedge clk);
        cfg_idx   = psra_pkg::REG_MAX_TEMP;
        cfg_wdata = hi;
        @(negedge clk);
        cfg_we     = 1'b0;
        cold_limit = lo;
        hot_limit  = hi;
    endtask

    // Receiver: stall for a drawn number of cycles before each result.
    initial begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            gap = rx_quiet ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                rx_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            rx_ready = 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            @(negedge clk);
        end
    end

    // Long hold-off mid-run: the sender keeps offering, so the block backs up.
    initial begin
        wait (items_taken >= HOLD_AFTER);
        @(negedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk) begin : check_alarm
        t_alarm_result got;
        t_alarm_result want;
        if (rst_n && m_tvalid && m_tready) begin
            got.status    = m_tuser;
            got.room      = m_tdata[15:0];
            got.average   = m_tdata[31:16];
            got.too_cold  = m_tdata[32];
            got.too_hot   = m_tdata[33];
            got.last_time = m_tdata[65:34];
            got.count     = m_tdata[70:66];
            if (expected_alarms.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected alarm item: status %0d room %h", got.status, got.room);
                error_count++;
            end else begin
                want = expected_alarms.pop_front();
                if (got.status !== want.status || got.room !== want.room
                        || got.average !== want.average || got.too_cold !== want.too_cold
                        || got.too_hot !== want.too_hot || got.last_time !== want.last_time
                        || got.count !== want.count) begin
                    if (error_count < 10) begin
                        $display("alarm mismatch: want st %0d room %h avg %0d c%b h%b t %h n %0d",
                                 want.status, want.room, want.average, want.too_cold,
                                 want.too_hot, want.last_time, want.count);
                        $display("                got  st %0d room %h avg %0d c%b h%b t %h n %0d",
                                 got.status, got.room, got.average, got.too_cold,
                                 got.too_hot, got.last_time, got.count);
                    end
                    error_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("per_sensor_running_average_alarm_test: errors");
        $finish;
    end

    initial begin
        t_sensor_item it;
        int roll;
        int mode;
        bit hit;
        logic signed [psra_pkg::TEMP_W-1:0] lo;
        logic signed [psra_pkg::TEMP_W-1:0] hi;

        map_used   = 0;
        cold_limit = psra_pkg::MIN_TEMP_RESET;
        hot_limit  = psra_pkg::MAX_TEMP_RESET;

        // Directed script: unknown id on an empty map, extreme ids and rooms,
        // a duplicate id, windows full of the extreme readings, truncation of
        // a negative average, filling status, then loads up to a full map.
        script = '{
            '{psra_pkg::OP_READING, 16'h1234, 16'h0, 16'h0, 16'sd100, 32'd5, 1, 1'b1,
              '{psra_pkg::ST_UNKNOWN, 16'h0, 16'sd0, 1'b0, 1'b0, 32'h0, 5'd0}},
            '{psra_pkg::OP_LOAD, 16'h0000, 16'h0, 16'hFFFF, 16'sd0, 32'd0, 1, 1'b1,
              '{psra_pkg::ST_LOADED, 16'hFFFF, 16'sd0, 1'b0, 1'b0, 32'h0, 5'd1}},
            '{psra_pkg::OP_LOAD, 16'hFFFF, 16'h0, 16'h0000, 16'sd0, 32'd0, 1, 1'b1,
              '{psra_pkg::ST_LOADED, 16'h0000, 16'sd0, 1'b0, 1'b0, 32'h0, 5'd2}},
            // same id again: accepted, but readings still go to the first entry
            '{psra_pkg::OP_LOAD, 16'hFFFF, 16'h0, 16'h5A5A, 16'sd0, 32'd0, 1, 1'b1,
              '{psra_pkg::ST_LOADED, 16'h5A5A, 16'sd0, 1'b0, 1'b0, 32'h0, 5'd3}},
            '{psra_pkg::OP_READING, 16'hFFFF, 16'h0, 16'hA5A5, 16'sh7FFF, 32'hFFFF_FFFF,
              8, 1'b1,
              '{psra_pkg::ST_VALID, 16'h0000, 16'sh7FFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 5'd3}},
            '{psra_pkg::OP_READING, 16'hFFFF, 16'h0, 16'h0, 16'sh8000, 32'd0, 8, 1'b1,
              '{psra_pkg::ST_VALID, 16'h0000, 16'sh8000, 1'b1, 1'b0, 32'h0, 5'd3}},
            '{psra_pkg::OP_READING, 16'hFFFF, 16'h0, 16'h0, 16'sd7, 32'h8000_0000, 1, 1'b0,
              '0},
            '{psra_pkg::OP_READING, 16'h0000, 16'h0, 16'h0, 16'sd1234, 32'd1, 1, 1'b1,
              '{psra_pkg::ST_FILLING, 16'hFFFF, 16'sd0, 1'b0, 1'b0, 32'd1, 5'd3}},
            '{psra_pkg::OP_READING, 16'h4321, 16'h0, 16'h0, 16'sd0, 32'd0, 1, 1'b1,
              '{psra_pkg::ST_UNKNOWN, 16'h0, 16'sd0, 1'b0, 1'b0, 32'h0, 5'd3}},
            '{psra_pkg::OP_LOAD, 16'h1000, 16'h0111, 16'h2000, 16'sd0, 32'd0, 13, 1'b1,
              '{psra_pkg::ST_LOADED, 16'h2000, 16'sd0, 1'b0, 1'b0, 32'h0, 5'd16}},
            '{psra_pkg::OP_LOAD, 16'hABCD, 16'h0, 16'h1357, 16'sd0, 32'd0, 1, 1'b1,
              '{psra_pkg::ST_FULL, 16'h0, 16'sd0, 1'b0, 1'b0, 32'h0, 5'd16}}
        };

        // Hold reset, then release on a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i]) begin
            for (int rep = 0; rep < script[i].reps; rep++) begin
                it.op    = script[i].op;
                it.sid   = script[i].sid + 16'(rep) * script[i].sid_step;
                it.room  = script[i].room;
                it.value = script[i].value;
                it.ts    = script[i].ts;
                offer_item(it, script[i].typed && rep == script[i].reps - 1, script[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            // Drain before touching the thresholds.
            s_tvalid = 1'b0;
            while (expected_alarms.size() != 0) @(negedge clk);
            unique case (ph)
                0: begin
                    lo = 16'sh8000;
                    hi = 16'sh7FFF;
                end
                1: begin
                    lo = 16'sh7FFF;
                    hi = 16'sh8000;
                end
                5: begin
                    lo = psra_pkg::MIN_TEMP_RESET;
                    hi = psra_pkg::MAX_TEMP_RESET;
                end
                default: begin
                    lo = 16'($urandom);
                    hi = 16'($urandom);
                end
            endcase
            set_limits(lo, hi);
            tx_quiet = $urandom_range(0, 3) == 0;
            rx_quiet = $urandom_range(0, 3) == 0;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll     = $urandom_range(0, 99);
                it.room  = 16'($urandom);
                it.ts    = 32'($urandom);
                mode     = $urandom_range(0, 3);
                unique case (mode)
                    0: it.value = 16'($urandom);
                    1: it.value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    2: it.value = cold_limit + $signed(16'($urandom_range(0, 512))) - 16'sd256;
                    default: it.value = hot_limit + $signed(16'($urandom_range(0, 512)))
                                        - 16'sd256;
                endcase
                if (roll < 8) begin
                    // map is full by now: these come back as table-full
                    it.op  = psra_pkg::OP_LOAD;
                    it.sid = 16'($urandom);
                end else if (roll < 16) begin
                    // draw an id that is not in the map
                    it.op = psra_pkg::OP_READING;
                    do begin
                        it.sid = 16'($urandom);
                        hit = 1'b0;
                        for (int k = 0; k < map_used; k++) begin
                            if (map_id[k] == it.sid) hit = 1'b1;
                        end
                    end while (hit);
                end else begin
                    it.op  = psra_pkg::OP_READING;
                    it.sid = map_id[$urandom_range(0, map_used - 1)];
                end
                offer_item(it, 1'b0, '0);
            end
        end

        // Stop offering, let every result come back, then allow for stragglers.
        s_tvalid = 1'b0;
        while (expected_alarms.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0 && expected_alarms.size() == 0) begin
            $display("per_sensor_running_average_alarm_test: clean");
        end else begin
            $display("per_sensor_running_average_alarm_test: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/psra_pkg.sv
sv/per_sensor_running_average_alarm.sv
bench/per_sensor_running_average_alarm_test.sv
